// File: src/dmv_pkg.sv
`default_nettype none
package dmv_pkg;

    // Storage geometry and number format
    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = DATA_WIDTH / 2;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = 64;

    localparam int VEC_DEPTH  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int RESULT_CAP = 16;
    localparam int CNT_TOP    = (VEC_DEPTH > RESULT_CAP) ? VEC_DEPTH : RESULT_CAP;

    localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int VEC_AW     = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int CNT_W      = $clog2(CNT_TOP + 1);
    localparam int RES_W      = $clog2(RESULT_CAP);

    // Port field widths
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 5;
    localparam int CFG_AW     = 2;
    localparam int REQ_W      = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_MAT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_VEC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_TRANS = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_MAT,
        CMD_VEC,
        CMD_RUN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [ADDR_W-1:0]       addr;
        logic [DATA_WIDTH-1:0]   value;
        logic [CNT_W-1:0]        nres;
        logic [CNT_W-1:0]        nterm;
        logic                    trans;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Element (row, col) sits at col * MAX_ROWS + row
    function automatic logic [ADDR_W-1:0] mat_addr(input logic [CNT_W-1:0] row,
                                                   input logic [CNT_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(col) * ADDR_W'(MAX_ROWS));
        return ADDR_W'(base + ADDR_W'(row));
    endfunction

    // Zero acts as one, anything above the store size as the store size
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input int top);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (int'(v) > top)
            r = CNT_W'(top);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/dmv_front.sv
`default_nettype none
module dmv_front
    import dmv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [REQ_W-1:0]      s_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_AW-1:0]     cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire q_status_t             q_status,
    output logic                       push,
    output cmd_t                       push_cmd
);

    logic [CFG_W-1:0]      rows_reg;
    logic [CFG_W-1:0]      cols_reg;
    logic                  trans_reg;
    logic [IDX_W-1:0]      row_idx;
    logic [IDX_W-1:0]      col_idx;
    logic [IDX_W-1:0]      vec_idx;
    logic [CNT_W-1:0]      rows_c;
    logic [CNT_W-1:0]      cols_c;
    logic [CNT_W-1:0]      nres_c;
    logic                  keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CFG_W'(16);
            cols_reg  <= CFG_W'(16);
            trans_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ROWS:  rows_reg  <= cfg_wdata;
                CFG_COLS:  cols_reg  <= cfg_wdata;
                CFG_TRANS: trans_reg <= cfg_wdata[0];
                default:   ;
            endcase
        end
    end

    assign s_tready = !q_status.full;
    assign row_idx  = s_tdata[3:0];
    assign col_idx  = s_tdata[7:4];
    assign vec_idx  = s_tdata[11:8];

    always_comb
    begin
        rows_c = clamp_count(rows_reg, MAX_ROWS);
        cols_c = clamp_count(cols_reg, MAX_COLS);
        nres_c = trans_reg ? cols_c : rows_c;
        if (int'(nres_c) > RESULT_CAP)
            nres_c = CNT_W'(RESULT_CAP);

        push_cmd.kind  = CMD_RUN;
        push_cmd.addr  = '0;
        push_cmd.value = s_tdata[12 +: DATA_WIDTH];
        push_cmd.nres  = nres_c;
        push_cmd.nterm = trans_reg ? rows_c : cols_c;
        push_cmd.trans = trans_reg;
        keep           = 1'b0;

        // Classify; drop out-of-range writes and the unused code
        case (s_tuser)
            REQ_MAT:
            begin
                push_cmd.kind = CMD_MAT;
                push_cmd.addr = mat_addr(CNT_W'(row_idx), CNT_W'(col_idx));
                keep = (int'(row_idx) < MAX_ROWS) && (int'(col_idx) < MAX_COLS);
            end
            REQ_VEC:
            begin
                push_cmd.kind = CMD_VEC;
                push_cmd.addr = ADDR_W'(vec_idx);
                keep = int'(vec_idx) < VEC_DEPTH;
            end
            REQ_RUN:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

// File: src/dmv_queue.sv
`default_nettype none
module dmv_queue
    import dmv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    input  wire logic  pop,
    output cmd_t       pop_cmd,
    output q_status_t  q_status
);

    cmd_t                entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign q_status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_cmd = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: src/dmv_back.sv
`default_nettype none
module dmv_back
    import dmv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire q_status_t             q_status,
    input  wire cmd_t                  pop_cmd,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [RES_W-1:0]          k_reg, k_next;
    logic [CNT_W-1:0]          t_reg, t_next;
    logic [CNT_W-1:0]          nres_reg, nres_next;
    logic [CNT_W-1:0]          nterm_reg, nterm_next;
    logic                      trans_reg, trans_next;
    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          out_index_reg, out_index_next;
    logic [VAL_W-1:0]          out_value_reg, out_value_next;
    logic                      out_sat_reg, out_sat_next;
    logic                      out_last_reg, out_last_next;

    logic [DATA_WIDTH-1:0]         mat_mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0]         vec_store [VEC_DEPTH];
    logic signed [DATA_WIDTH-1:0]  mat_rd_reg;
    logic signed [DATA_WIDTH-1:0]  vec_rd_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      term;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          mat_we;
    logic                          vec_we;
    logic [ACC_W-DATA_WIDTH:0]     acc_upper;
    logic                          sat;
    logic signed [DATA_WIDTH-1:0]  sat_val;
    logic                          is_last;
    logic                          out_free;

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign mat_we   = pop && (pop_cmd.kind == CMD_MAT);
    assign vec_we   = pop && (pop_cmd.kind == CMD_VEC);
    assign rd_addr  = trans_reg ? mat_addr(t_reg, CNT_W'(k_reg))
                                : mat_addr(CNT_W'(k_reg), t_reg);
    assign prod_next = mat_rd_reg * vec_rd_reg;
    assign term      = prod_reg >>> FRAC_BITS;

    // Clip to the signed data range
    assign acc_upper = acc_reg[ACC_W-1:DATA_WIDTH-1];
    assign sat       = !((&acc_upper) || (~|acc_upper));
    assign sat_val   = !sat ? acc_reg[DATA_WIDTH-1:0]
                     : (acc_reg[ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                         : {1'b0, {(DATA_WIDTH-1){1'b1}}});
    assign is_last   = ((CNT_W'(k_reg) + CNT_W'(1)) == nres_reg);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        nres_next      = nres_reg;
        nterm_next     = nterm_reg;
        trans_next     = trans_reg;
        v1_next        = (state_reg == ST_ISSUE);
        v2_next        = v1_reg;
        acc_next       = v2_reg ? acc_reg + ACC_W'(term) : acc_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (pop_cmd.kind == CMD_RUN))
                begin
                    nres_next  = pop_cmd.nres;
                    nterm_next = pop_cmd.nterm;
                    trans_next = pop_cmd.trans;
                    k_next     = '0;
                    t_next     = '0;
                    acc_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                t_next = t_reg + 1'b1;
                if ((t_reg + 1'b1) == nterm_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = IDX_W'(k_reg);
                    out_value_next = VAL_W'(sat_val);
                    out_sat_next   = sat;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        t_next     = '0;
                        acc_next   = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            t_reg         <= '0;
            nres_reg      <= CNT_W'(1);
            nterm_reg     <= CNT_W'(1);
            trans_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            nres_reg      <= nres_next;
            nterm_reg     <= nterm_next;
            trans_reg     <= trans_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Matrix memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[pop_cmd.addr] <= pop_cmd.value;
        mat_rd_reg <= mat_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
            vec_store[pop_cmd.addr[VEC_AW-1:0]] <= pop_cmd.value;
        vec_rd_reg <= vec_store[t_reg[VEC_AW-1:0]];
        prod_reg   <= prod_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-IDX_W-VAL_W){1'b0}}, out_value_reg, out_index_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!v1_reg && !v2_reg))
        else $error("result taken before the product pipeline drained");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (t_reg < nterm_reg))
        else $error("term counter past the term count");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (CNT_W'(k_reg) < nres_reg))
        else $error("result counter past the result count");

    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("product stage valid without an operand read");

endmodule
`default_nettype wire

// File: src/dense_matrix_vector_multiply_unit.sv
// Load requests (matrix or vector element writes) are taken one per cycle while the queue
// has room; each is written into a queue entry, then popped into storage when the back end is idle.
// A compute request yields one result per output element; each element is formed by
// the single multiply-accumulate loop reading one matrix word per cycle from the matrix memory,
// followed by a drain of the operand read, product and accumulate registers.
// Reset (rst_n low, asynchronous) clears control, queue and accumulator; stores stay undefined.
`default_nettype none
module dense_matrix_vector_multiply_unit
    import dmv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [3:0] row_index, [7:4] col_index, [11:8] vec_index, [43:12] elem_value
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  wire logic [REQ_W-1:0]      s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [3:0] out_index, [35:4] out_value
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // [0] sat_flag
    output logic                       m_tuser,
    output logic                       m_tlast,
    // Configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_AW-1:0]     cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    // Front side: classified requests heading into the queue
    q_status_t  q_status;
    logic       push;
    cmd_t       push_cmd;
    // Back side: head of the queue
    logic       pop;
    cmd_t       pop_cmd;

    // Hold configuration, decode each request, drop the ones that do nothing
    dmv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Decouple intake from the multiply loop so loads keep streaming
    dmv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // Write stores, run the MAC sequence, hold each result until taken
    dmv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: sim/dense_matrix_vector_multiply_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module dense_matrix_vector_multiply_unit_test;
    import dmv_pkg::*;

    // Request type with no meaning to the block, and a register index past the list
    localparam logic [REQ_W-1:0]  REQ_NONE   = 2'd3;
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

    localparam int     HALF_PERIOD   = 10;
    localparam int     RESET_CYCLES  = 5;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     PHASE_ITEMS   = 6;
    localparam int     NUM_PHASES    = 9;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint SUM_MAX       = 64'sd2147483647;
    localparam longint SUM_MIN       = -64'sd2147483648;

    // One request on the input stream
    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  vix;
        logic [VAL_W-1:0]  value;
    } dmv_request_t;

    // One element of the product vector
    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic              sat;
        logic              last;
    } dmv_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire logic              s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [REQ_W-1:0]       s_tuser   = '0;
    wire logic              m_tvalid;
    logic                   m_tready  = 1'b0;
    wire logic [OUT_DATA_W-1:0] m_tdata;
    wire logic              m_tuser;
    wire logic              m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // Shadow copy of the block's stores and registers
    logic [VAL_W-1:0]  matrix_copy [MAX_ROWS][MAX_COLS];
    logic [VAL_W-1:0]  vector_copy [VEC_DEPTH];
    logic [CFG_W-1:0]  rows_cfg  = 5'd16;
    logic [CFG_W-1:0]  cols_cfg  = 5'd16;
    logic              trans_cfg = 1'b0;

    dmv_request_t pending_requests [$];
    dmv_result_t  expected_results [$];
    dmv_request_t offered;

    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    logic hold_go   = 1'b0;
    logic recv_hold = 1'b0;

    dense_matrix_vector_multiply_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Work out the product vector for the current registers and queue every element
    function automatic void predict_product();
        int               n_rows;
        int               n_cols;
        int               n_out;
        int               n_terms;
        longint           acc;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] x;
        dmv_result_t      res;
        // A count of zero acts as one, anything past the store as the store size
        n_rows  = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg));
        n_cols  = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg));
        n_out   = trans_cfg ? n_cols : n_rows;
        n_terms = trans_cfg ? n_rows : n_cols;
        if (n_out > RESULT_CAP)
            n_out = RESULT_CAP;
        for (int k = 0; k < n_out; k++)
        begin
            acc = 0;
            for (int t = 0; t < n_terms; t++)
            begin
                a = trans_cfg ? matrix_copy[t][k] : matrix_copy[k][t];
                x = vector_copy[t];
                // Arithmetic shift of the exact product floors toward minus infinity
                acc += (longint'(a) * longint'(x)) >>> FRAC_BITS;
            end
            res.sat = 1'b0;
            if (acc > SUM_MAX)
            begin
                acc     = SUM_MAX;
                res.sat = 1'b1;
            end
            else if (acc < SUM_MIN)
            begin
                acc     = SUM_MIN;
                res.sat = 1'b1;
            end
            res.index = IDX_W'(k);
            res.value = acc[VAL_W-1:0];
            res.last  = (k + 1 == n_out);
            expected_results.push_back(res);
        end
    endfunction

    // Update the shadow state with one accepted request
    function automatic void apply_request(input dmv_request_t req);
        case (req.kind)
            REQ_MAT: matrix_copy[req.row][req.col] = req.value;
            REQ_VEC: vector_copy[req.vix] = req.value;
            REQ_RUN: predict_product();
            default: ;
        endcase
    endfunction

    // Mostly moderate values that keep sums in range, with some extremes and full-range noise
    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4)
        begin
            case ($urandom_range(4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (sel < 10)
            return $urandom;
        return 32'($urandom_range(2097151)) - 32'd1048576;
    endfunction

    function automatic logic [VAL_W-1:0] moderate_value();
        return 32'($urandom_range(2097151)) - 32'd1048576;
    endfunction

    task automatic queue_request(input logic [REQ_W-1:0] kind, input int row, input int col,
                                 input int vix, input logic [VAL_W-1:0] value);
        dmv_request_t req;
        req.kind  = kind;
        req.row   = IDX_W'(row);
        req.col   = IDX_W'(col);
        req.vix   = IDX_W'(vix);
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // Random request: unused fields carry garbage so every bit toggles
    task automatic queue_random_request();
        int unsigned       sel;
        logic [REQ_W-1:0]  kind;
        sel = $urandom_range(99);
        if (sel < 45)
            kind = REQ_MAT;
        else if (sel < 73)
            kind = REQ_VEC;
        else if (sel < 93)
            kind = REQ_RUN;
        else
            kind = REQ_NONE;
        queue_request(kind, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                      pick_value());
    endtask

    // Write one register at a rising edge and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ROWS:  rows_cfg  = val;
            CFG_COLS:  cols_cfg  = val;
            CFG_TRANS: trans_cfg = val[0];
            default:   ;
        endcase
    endtask

    // Hold the sender until every request is taken and every result is back,
    // then let queued loads settle inside the block
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Driver: present the next pending request, idling at the configured rate
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                apply_request(offered);
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered  = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'({offered.value, offered.vix, offered.col,
                                            offered.row});
                    s_tuser  <= offered.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        dmv_result_t exp_res;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: idx %0d value %h sat %0b last %0b",
                                 m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata[3:0] !== exp_res.index || m_tdata[35:4] !== exp_res.value ||
                        m_tuser !== exp_res.sat || m_tlast !== exp_res.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("result mismatch: exp idx %0d value %h sat %0b last %0b, got idx %0d value %h sat %0b last %0b",
                                     exp_res.index, exp_res.value, exp_res.sat, exp_res.last,
                                     m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast);
                    end
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile
    always
    begin
        wait (hold_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
        wait (!hold_go);
    end

    // Watchdog: fail the run once the cycle count reaches the limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Sender-light/receiver-heavy idling, then the reverse, then none
            @(negedge clk);
            case (ph / 3)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case (ph)
                0:
                begin
                    write_reg(CFG_ROWS, 5'd16);
                    write_reg(CFG_COLS, 5'd16);
                    write_reg(CFG_TRANS, 5'd0);
                    // Fill both stores so no compute ever reads an unwritten entry
                    for (int c = 0; c < MAX_COLS; c++)
                        for (int r = 0; r < MAX_ROWS; r++)
                            queue_request(REQ_MAT, r, c, $urandom_range(15), moderate_value());
                    for (int v = 0; v < VEC_DEPTH; v++)
                        queue_request(REQ_VEC, $urandom_range(15), $urandom_range(15), v,
                                      moderate_value());
                    queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                    // Positive clip on row 0, negative clip on row 1
                    queue_request(REQ_MAT, 0, 0, 0, 32'h7FFF_FFFF);
                    queue_request(REQ_MAT, 0, 1, 0, 32'h7FFF_FFFF);
                    queue_request(REQ_VEC, 0, 0, 0, 32'h7FFF_FFFF);
                    queue_request(REQ_VEC, 0, 0, 1, 32'h7FFF_FFFF);
                    queue_request(REQ_MAT, 1, 0, 0, 32'h8000_0000);
                    // Smallest negative and positive steps: floor rounding on both signs
                    queue_request(REQ_MAT, 2, 0, 0, 32'hFFFF_FFFF);
                    queue_request(REQ_MAT, 3, 0, 0, 32'h0000_0001);
                    queue_request(REQ_MAT, 4, 0, 0, 32'h0000_0000);
                    // Unused request type must do nothing
                    queue_request(REQ_NONE, 15, 15, 15, $urandom);
                    queue_request(REQ_RUN, 15, 15, 15, 32'hFFFF_FFFF);
                    // Most negative times most negative
                    queue_request(REQ_VEC, 0, 0, 0, 32'h8000_0000);
                    queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                    queue_request(REQ_VEC, 0, 0, 0, moderate_value());
                    queue_request(REQ_VEC, 0, 0, 1, moderate_value());
                    queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                end
                1:
                begin
                    // Zero rows acts as one, oversize columns as the store size
                    write_reg(CFG_ROWS, 5'd0);
                    write_reg(CFG_COLS, 5'd31);
                    write_reg(CFG_TRANS, 5'd1);
                    write_reg(CFG_UNUSED, 5'($urandom));
                    queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                end
                2:
                begin
                    write_reg(CFG_ROWS, 5'd1);
                    write_reg(CFG_COLS, 5'd1);
                    write_reg(CFG_TRANS, 5'd0);
                    queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                end
                3:
                begin
                    write_reg(CFG_ROWS, 5'd16);
                    write_reg(CFG_COLS, 5'd16);
                    write_reg(CFG_TRANS, 5'd31);
                    queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                end
                default:
                begin
                    write_reg(CFG_ROWS, 5'($urandom_range(0, 20)));
                    write_reg(CFG_COLS, 5'($urandom_range(0, 20)));
                    write_reg(CFG_TRANS, 5'($urandom));
                    if (ph == 6)
                    begin
                        // Stall the receiver and pile up computes so the input backs up
                        hold_go = 1'b1;
                        repeat (6) queue_request(REQ_RUN, 0, 0, 0, 32'h0);
                    end
                end
            endcase

            repeat (PHASE_ITEMS) queue_random_request();
            wait_quiet();
            hold_go = 1'b0;
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
